### hdl/max_pool_2d_with_argmax_unit_assert.svh
// ---------------------------------------------------------------------------
// max pool assertion macros
// immediate-implication and next-cycle-implication property wrappers
// ---------------------------------------------------------------------------
`ifndef MAX_POOL_2D_WITH_ARGMAX_UNIT_ASSERT_SVH
`define MAX_POOL_2D_WITH_ARGMAX_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MP2A_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MP2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mp2a_pkg.sv
// ---------------------------------------------------------------------------
// mp2a_pkg
// shared types and constants of the max pool with argmax unit
// ---------------------------------------------------------------------------
`default_nettype none

package mp2a_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 2'd2;

    localparam int POOL_REG_W  = 4;
    localparam int WIDTH_REG_W = 7;
    localparam int CHAN_REG_W  = 5;

    localparam logic [POOL_REG_W-1:0]  POOL_RESET  = 4'd2;
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 7'd64;
    localparam logic [CHAN_REG_W-1:0]  CHAN_RESET  = 5'd1;

    localparam int OUT_COORD_W = 6;
    localparam int OUT_CHAN_W  = 4;
    localparam int OUT_ARG_W   = 3;

    // per-sample window flags from the position tracker
    typedef struct packed {
        logic ok;          // configuration usable
        logic first;       // first sample of its window
        logic last_win;    // last sample of its window
        logic last_frame;  // last sample of the map
    } win_flags_t;

endpackage

`default_nettype wire

### hdl/mp2a_ram.sv
// ---------------------------------------------------------------------------
// mp2a_ram
// simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module mp2a_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/mp2a_ctrl.sv
// ---------------------------------------------------------------------------
// mp2a_ctrl
// configuration registers, map position counters and store address
// after reset or a register write, a subtract loop rebuilds the window
// offsets and the divisibility check before samples are taken again
// ---------------------------------------------------------------------------
`default_nettype none

module mp2a_ctrl
    import mp2a_pkg::*;
#(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_POOL     = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                        frame_start,
    input  wire logic                        take,
    output logic                             busy,
    output win_flags_t                       cur_flags,
    output logic [$clog2(MAX_WIDTH)-1:0]     cur_orow,
    output logic [$clog2(MAX_WIDTH)-1:0]     cur_ocol,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] cur_ch,
    output logic [$clog2(MAX_POOL)-1:0]      cur_wr,
    output logic [$clog2(MAX_POOL)-1:0]      cur_wc,
    output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0] cur_addr
);

    localparam int POS_W  = $clog2(MAX_WIDTH);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int OFF_W  = $clog2(MAX_POOL);
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_CHANNELS);
    localparam int CMP_W  = ((POS_W > CH_W) ? POS_W : CH_W) + 7;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [POOL_REG_W-1:0]  pool_reg, pool_next;
    logic [WIDTH_REG_W-1:0] inw_reg, inw_next;
    logic [CHAN_REG_W-1:0]  chans_reg, chans_next;
    logic                   ok_reg, ok_next;

    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [OFF_W-1:0] wr_reg, wr_next;
    logic [OFF_W-1:0] wc_reg, wc_next;
    logic [POS_W-1:0] orow_reg, orow_next;
    logic [POS_W-1:0] ocol_reg, ocol_next;

    logic [CMP_W-1:0] rem_r_reg, rem_r_next;
    logic [CMP_W-1:0] rem_c_reg, rem_c_next;
    logic [CMP_W-1:0] rem_w_reg, rem_w_next;

    logic [CMP_W-1:0] p_x, w_x, n_x;
    logic             range_ok;
    logic             restart;
    logic [POS_W-1:0] r0, c0, orow0, ocol0;
    logic [CH_W-1:0]  ch0;
    logic [OFF_W-1:0] wr0, wc0;
    logic [CMP_W-1:0] r1, c1, ch1, wr1, wc1;

    assign p_x = CMP_W'(pool_reg);
    assign w_x = CMP_W'(inw_reg);
    assign n_x = CMP_W'(chans_reg);

    assign range_ok = (pool_reg != '0) && (p_x <= CMP_W'(MAX_POOL))
                   && (inw_reg != '0) && (w_x <= CMP_W'(MAX_WIDTH))
                   && (chans_reg != '0) && (n_x <= CMP_W'(MAX_CHANNELS));

    assign busy = (state_reg != ST_IDLE);

    // out-of-map position after a register write counts as a frame start
    assign restart = frame_start || (CMP_W'(row_reg) >= w_x)
                  || (CMP_W'(col_reg) >= w_x) || (CMP_W'(ch_reg) >= n_x);

    assign r0    = restart ? '0 : row_reg;
    assign c0    = restart ? '0 : col_reg;
    assign ch0   = restart ? '0 : ch_reg;
    assign wr0   = restart ? '0 : wr_reg;
    assign wc0   = restart ? '0 : wc_reg;
    assign orow0 = restart ? '0 : orow_reg;
    assign ocol0 = restart ? '0 : ocol_reg;

    assign r1  = CMP_W'(r0) + CMP_W'(1);
    assign c1  = CMP_W'(c0) + CMP_W'(1);
    assign ch1 = CMP_W'(ch0) + CMP_W'(1);
    assign wr1 = CMP_W'(wr0) + CMP_W'(1);
    assign wc1 = CMP_W'(wc0) + CMP_W'(1);

    assign cur_flags.ok         = ok_reg;
    assign cur_flags.first      = (wr0 == '0) && (wc0 == '0);
    assign cur_flags.last_win   = (wr1 == p_x) && (wc1 == p_x);
    assign cur_flags.last_frame = (r1 == w_x) && (c1 == w_x) && (ch1 == n_x);

    assign cur_orow = orow0;
    assign cur_ocol = ocol0;
    assign cur_ch   = ch0;
    assign cur_wr   = wr0;
    assign cur_wc   = wc0;
    assign cur_addr = ADDR_W'(ADDR_W'(ocol0) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(ch0));

    always_comb
    begin
        state_next = state_reg;
        pool_next  = pool_reg;
        inw_next   = inw_reg;
        chans_next = chans_reg;
        ok_next    = ok_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ch_next    = ch_reg;
        wr_next    = wr_reg;
        wc_next    = wc_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        rem_r_next = rem_r_reg;
        rem_c_next = rem_c_reg;
        rem_w_next = rem_w_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (take && ok_reg)
                begin
                    row_next  = r0;
                    col_next  = c0;
                    wr_next   = wr0;
                    wc_next   = wc0;
                    orow_next = orow0;
                    ocol_next = ocol0;
                    ch_next   = CH_W'(ch1);
                    if (ch1 >= n_x)
                    begin
                        ch_next = '0;
                        if (c1 >= w_x)
                        begin
                            col_next  = '0;
                            wc_next   = '0;
                            ocol_next = '0;
                            if (r1 >= w_x)
                            begin
                                row_next  = '0;
                                wr_next   = '0;
                                orow_next = '0;
                            end
                            else
                            begin
                                row_next = POS_W'(r1);
                                if (wr1 == p_x)
                                begin
                                    wr_next   = '0;
                                    orow_next = orow0 + POS_W'(1);
                                end
                                else
                                begin
                                    wr_next = OFF_W'(wr1);
                                end
                            end
                        end
                        else
                        begin
                            col_next = POS_W'(c1);
                            if (wc1 == p_x)
                            begin
                                wc_next   = '0;
                                ocol_next = ocol0 + POS_W'(1);
                            end
                            else
                            begin
                                wc_next = OFF_W'(wc1);
                            end
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                rem_r_next = CMP_W'(row_reg);
                rem_c_next = CMP_W'(col_reg);
                rem_w_next = w_x;
                orow_next  = '0;
                ocol_next  = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!range_ok)
                begin
                    ok_next    = 1'b0;
                    state_next = ST_IDLE;
                end
                else if ((rem_r_reg < p_x) && (rem_c_reg < p_x) && (rem_w_reg < p_x))
                begin
                    wr_next    = OFF_W'(rem_r_reg);
                    wc_next    = OFF_W'(rem_c_reg);
                    ok_next    = (rem_w_reg == '0);
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (rem_r_reg >= p_x)
                    begin
                        rem_r_next = rem_r_reg - p_x;
                        orow_next  = orow_reg + POS_W'(1);
                    end
                    if (rem_c_reg >= p_x)
                    begin
                        rem_c_next = rem_c_reg - p_x;
                        ocol_next  = ocol_reg + POS_W'(1);
                    end
                    if (rem_w_reg >= p_x)
                    begin
                        rem_w_next = rem_w_reg - p_x;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // a register write always restarts the rebuild
        if (cfg_we)
        begin
            state_next = ST_LOAD;
            case (cfg_index)
                CFG_POOL_WIDTH: pool_next  = POOL_REG_W'(cfg_data);
                CFG_IN_WIDTH:   inw_next   = WIDTH_REG_W'(cfg_data);
                CFG_CHANNELS:   chans_next = CHAN_REG_W'(cfg_data);
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            pool_reg  <= POOL_RESET;
            inw_reg   <= WIDTH_RESET;
            chans_reg <= CHAN_RESET;
            ok_reg    <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            ch_reg    <= '0;
            wr_reg    <= '0;
            wc_reg    <= '0;
            orow_reg  <= '0;
            ocol_reg  <= '0;
            rem_r_reg <= '0;
            rem_c_reg <= '0;
            rem_w_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pool_reg  <= pool_next;
            inw_reg   <= inw_next;
            chans_reg <= chans_next;
            ok_reg    <= ok_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            ch_reg    <= ch_next;
            wr_reg    <= wr_next;
            wc_reg    <= wc_next;
            orow_reg  <= orow_next;
            ocol_reg  <= ocol_next;
            rem_r_reg <= rem_r_next;
            rem_c_reg <= rem_c_next;
            rem_w_reg <= rem_w_next;
        end
    end

endmodule

`default_nettype wire

### hdl/max_pool_2d_with_argmax_unit.sv
// path: the last sample of a window passes the read stage, then the output register
// throughput: one sample per cycle while not busy and the read stage is not stalled;
// the line store is read on accept and written back from the read stage, with the last
// write forwarded so back-to-back hits on one entry work; the line store is never cleared
// reset: control state clears at once; ready then stays low while window offsets and the
// divisibility check are rebuilt, and each register write causes the same rebuild
`default_nettype none

// ---------------------------------------------------------------------------
// max_pool_2d_with_argmax_unit
// streaming non-overlapping max pooling with argmax over a square feature map
// ---------------------------------------------------------------------------
`include "max_pool_2d_with_argmax_unit_assert.svh"

module max_pool_2d_with_argmax_unit
    import mp2a_pkg::*;
#(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_POOL     = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          frame_start,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      max_value,
    output logic [OUT_COORD_W-1:0]             out_row,
    output logic [OUT_COORD_W-1:0]             out_col,
    output logic [OUT_CHAN_W-1:0]              channel,
    output logic [OUT_ARG_W-1:0]               arg_row,
    output logic [OUT_ARG_W-1:0]               arg_col,
    output logic                               last_of_frame,
    output logic                               bad_config
);

    localparam int POS_W  = $clog2(MAX_WIDTH);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int OFF_W  = $clog2(MAX_POOL);
    localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ENT_W  = SAMPLE_BITS + 2 * OFF_W;

    logic             busy;
    logic             in_fire;
    win_flags_t       cur_flags;
    logic [POS_W-1:0] cur_orow, cur_ocol;
    logic [CH_W-1:0]  cur_ch;
    logic [OFF_W-1:0] cur_wr, cur_wc;
    logic [ADDR_W-1:0] cur_addr;

    // stage 1: sample waiting on the line store read
    logic                          s1_valid_reg, s1_valid_next;
    win_flags_t                    s1_flags_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [POS_W-1:0]              s1_orow_reg, s1_ocol_reg;
    logic [CH_W-1:0]               s1_ch_reg;
    logic [OFF_W-1:0]              s1_wr_reg, s1_wc_reg;
    logic [ADDR_W-1:0]             s1_addr_reg;

    logic                 fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0]    fwd_addr_reg;
    logic [ENT_W-1:0]     fwd_data_reg;

    logic                 out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_max_reg;
    logic [OUT_COORD_W-1:0] out_row_reg, out_col_reg;
    logic [OUT_CHAN_W-1:0]  out_ch_reg;
    logic [OUT_ARG_W-1:0]   out_ar_reg, out_ac_reg;
    logic                   out_last_reg, out_bad_reg;

    logic [ENT_W-1:0]     rdata;
    logic [ENT_W-1:0]     old_ent, new_ent;
    logic signed [SAMPLE_BITS-1:0] old_val;
    logic                 s1_emit, s1_fire, wr_en;

    mp2a_ctrl #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_POOL    (MAX_POOL)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .frame_start(frame_start),
        .take       (in_fire),
        .busy       (busy),
        .cur_flags  (cur_flags),
        .cur_orow   (cur_orow),
        .cur_ocol   (cur_ocol),
        .cur_ch     (cur_ch),
        .cur_wr     (cur_wr),
        .cur_wc     (cur_wc),
        .cur_addr   (cur_addr)
    );

    mp2a_ram #(
        .WIDTH(ENT_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (wr_en),
        .waddr(s1_addr_reg),
        .wdata(new_ent),
        .re   (in_fire),
        .raddr(cur_addr),
        .rdata(rdata)
    );

    assign s1_emit  = s1_flags_reg.last_win || !s1_flags_reg.ok;
    assign s1_fire  = s1_valid_reg && (!s1_emit || !out_valid_reg || out_ready);
    assign in_ready = !busy && (!s1_valid_reg || s1_fire);
    assign in_fire  = in_valid && in_ready;
    assign wr_en    = s1_fire && s1_flags_reg.ok;

    // the most recent write may not yet be visible in the read data
    assign old_ent = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rdata;
    assign old_val = old_ent[ENT_W-1 -: SAMPLE_BITS];

    always_comb
    begin
        if (s1_flags_reg.first || (s1_sample_reg > old_val))
        begin
            new_ent = {s1_sample_reg, s1_wr_reg, s1_wc_reg};
        end
        else
        begin
            new_ent = old_ent;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        fwd_valid_next = fwd_valid_reg || wr_en;

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_flags_reg  <= cur_flags;
            s1_sample_reg <= sample;
            s1_orow_reg   <= cur_orow;
            s1_ocol_reg   <= cur_ocol;
            s1_ch_reg     <= cur_ch;
            s1_wr_reg     <= cur_wr;
            s1_wc_reg     <= cur_wc;
            s1_addr_reg   <= cur_addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= new_ent;
        end
        if (s1_fire && s1_emit)
        begin
            if (s1_flags_reg.ok)
            begin
                out_max_reg  <= new_ent[ENT_W-1 -: SAMPLE_BITS];
                out_row_reg  <= OUT_COORD_W'(s1_orow_reg);
                out_col_reg  <= OUT_COORD_W'(s1_ocol_reg);
                out_ch_reg   <= OUT_CHAN_W'(s1_ch_reg);
                out_ar_reg   <= OUT_ARG_W'(new_ent[2*OFF_W-1 -: OFF_W]);
                out_ac_reg   <= OUT_ARG_W'(new_ent[OFF_W-1:0]);
                out_last_reg <= s1_flags_reg.last_frame;
                out_bad_reg  <= 1'b0;
            end
            else
            begin
                out_max_reg  <= '0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                out_ch_reg   <= '0;
                out_ar_reg   <= '0;
                out_ac_reg   <= '0;
                out_last_reg <= 1'b0;
                out_bad_reg  <= 1'b1;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign max_value     = out_max_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign channel       = out_ch_reg;
    assign arg_row       = out_ar_reg;
    assign arg_col       = out_ac_reg;
    assign last_of_frame = out_last_reg;
    assign bad_config    = out_bad_reg;

    `MP2A_ASSERT_NOW(a_bad_zero, out_valid && bad_config,
        (max_value == '0) && (out_row == '0) && (out_col == '0) && (channel == '0)
        && (arg_row == '0) && (arg_col == '0) && !last_of_frame, "bad transaction not cleared")
    `MP2A_ASSERT_NOW(a_stall_blocks, s1_valid_reg && !s1_fire, !in_ready,
        "transaction accepted over a stalled read stage")
    `MP2A_ASSERT_NOW(a_busy_blocks, busy, !in_ready,
        "transaction accepted during offset rebuild")
    `MP2A_ASSERT_NEXT(a_out_load, s1_fire && s1_emit, out_valid,
        "result lost between read stage and output register")

endmodule

`default_nettype wire

### dv/max_pool_argmax_checker.sv
// ---------------------------------------------------------------------------
// max_pool_argmax_checker
// watches the configuration port and both channels, works out each pooled
// transaction from the accepted samples and compares results field by field
// ---------------------------------------------------------------------------
`default_nettype none

module max_pool_argmax_checker
    import mp2a_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic signed [15:0]     sample,
    input  wire logic                   frame_start,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic signed [15:0]     max_value,
    input  wire logic [OUT_COORD_W-1:0] out_row,
    input  wire logic [OUT_COORD_W-1:0] out_col,
    input  wire logic [OUT_CHAN_W-1:0]  channel,
    input  wire logic [OUT_ARG_W-1:0]   arg_row,
    input  wire logic [OUT_ARG_W-1:0]   arg_col,
    input  wire logic                   last_of_frame,
    input  wire logic                   bad_config,
    output int                          error_count,
    output int                          pending
);

    localparam int WIDTH_LIMIT = 64;
    localparam int CHAN_LIMIT  = 16;
    localparam int POOL_LIMIT  = 8;
    localparam int LINE_DEPTH  = WIDTH_LIMIT * CHAN_LIMIT;

    typedef struct packed {
        logic [15:0]            max_value;
        logic [OUT_COORD_W-1:0] out_row;
        logic [OUT_COORD_W-1:0] out_col;
        logic [OUT_CHAN_W-1:0]  channel;
        logic [OUT_ARG_W-1:0]   arg_row;
        logic [OUT_ARG_W-1:0]   arg_col;
        logic                   last_of_frame;
        logic                   bad_config;
    } pooled_t;

    pooled_t pooled_due[$];

    // running maximum and its window offset per output column and channel
    logic signed [15:0]   line_max     [LINE_DEPTH];
    logic [OUT_ARG_W-1:0] line_arg_row [LINE_DEPTH];
    logic [OUT_ARG_W-1:0] line_arg_col [LINE_DEPTH];

    int cur_row;
    int cur_col;
    int cur_chan;
    int pool_w;
    int map_w;
    int n_chan;
    int slot;

    function automatic bit map_usable();
        return pool_w >= 1 && pool_w <= POOL_LIMIT && map_w >= 1 && map_w <= WIDTH_LIMIT
            && n_chan >= 1 && n_chan <= CHAN_LIMIT && (map_w % pool_w) == 0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: pooled result mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic pool_sample(input logic signed [15:0] value, input logic start);
        pooled_t res;
        int      r;
        int      c;
        int      ch;
        int      oc;
        int      wr;
        int      wc;
        int      idx;
        res = '0;
        if (!map_usable())
        begin
            // position holds still and the line store is left alone
            res.bad_config = 1'b1;
            pooled_due.push_back(res);
        end
        else
        begin
            if (start || cur_row >= map_w || cur_col >= map_w || cur_chan >= n_chan)
            begin
                cur_row  = 0;
                cur_col  = 0;
                cur_chan = 0;
            end
            r   = cur_row;
            c   = cur_col;
            ch  = cur_chan;
            oc  = c / pool_w;
            wr  = r % pool_w;
            wc  = c % pool_w;
            idx = oc * CHAN_LIMIT + ch;
            if (idx >= LINE_DEPTH)
                idx = 0;

            if (wr == 0 && wc == 0)
            begin
                line_max[idx]     = value;
                line_arg_row[idx] = '0;
                line_arg_col[idx] = '0;
            end
            else if (value > line_max[idx])
            begin
                // strictly greater, so ties keep the first maximum
                line_max[idx]     = value;
                line_arg_row[idx] = wr;
                line_arg_col[idx] = wc;
            end

            cur_chan = ch + 1;
            if (cur_chan >= n_chan)
            begin
                cur_chan = 0;
                cur_col  = c + 1;
                if (cur_col >= map_w)
                begin
                    cur_col = 0;
                    cur_row = r + 1;
                    if (cur_row >= map_w)
                        cur_row = 0;
                end
            end

            if (wr == pool_w - 1 && wc == pool_w - 1)
            begin
                res.max_value     = line_max[idx];
                res.out_row       = r / pool_w;
                res.out_col       = oc;
                res.channel       = ch;
                res.arg_row       = line_arg_row[idx];
                res.arg_col       = line_arg_col[idx];
                res.last_of_frame = (r == map_w - 1 && c == map_w - 1 && ch == n_chan - 1);
                pooled_due.push_back(res);
            end
        end
    endtask

    task automatic check_result();
        pooled_t want;
        if (pooled_due.size() == 0)
            report_mismatch("result transaction with nothing outstanding");
        else
        begin
            want = pooled_due.pop_front();
            check_field("max_value", $signed(max_value), $signed(want.max_value));
            check_field("out_row", out_row, want.out_row);
            check_field("out_col", out_col, want.out_col);
            check_field("channel", channel, want.channel);
            check_field("arg_row", arg_row, want.arg_row);
            check_field("arg_col", arg_col, want.arg_col);
            check_field("last_of_frame", last_of_frame, want.last_of_frame);
            check_field("bad_config", bad_config, want.bad_config);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pooled_due.delete();
            for (slot = 0; slot < LINE_DEPTH; slot++)
            begin
                line_max[slot]     = '0;
                line_arg_row[slot] = '0;
                line_arg_col[slot] = '0;
            end
            cur_row     = 0;
            cur_col     = 0;
            cur_chan    = 0;
            pool_w      = POOL_RESET;
            map_w       = WIDTH_RESET;
            n_chan      = CHAN_RESET;
            error_count = 0;
            pending     = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                pool_sample(sample, frame_start);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POOL_WIDTH: pool_w = cfg_data[POOL_REG_W-1:0];
                    CFG_IN_WIDTH:   map_w  = cfg_data[WIDTH_REG_W-1:0];
                    CFG_CHANNELS:   n_chan = cfg_data[CHAN_REG_W-1:0];
                    default:        ;
                endcase
            end
            pending = pooled_due.size();
        end
    end

endmodule

`default_nettype wire

### dv/tb_max_pool_2d_with_argmax_unit.sv
// ---------------------------------------------------------------------------
// tb_max_pool_2d_with_argmax_unit
// drives feature maps through the max pool unit under many window, map and
// channel settings, with random idling on both sides and a long output stall;
// the checker beside the block predicts and compares every pooled result
// ---------------------------------------------------------------------------
`default_nettype none

module tb_max_pool_2d_with_argmax_unit;
    import mp2a_pkg::*;

    localparam int RANDOM_ITEMS  = 400;
    localparam int GAP_MAX       = 18;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int POOL_LIMIT    = 8;
    localparam int PHASE_CAP     = 120;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic signed [15:0]   MOST_NEG  = 16'sh8000;
    localparam logic signed [15:0]   MOST_POS  = 16'sh7fff;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [15:0]     sample;
    logic                   frame_start;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [15:0]     max_value;
    logic [OUT_COORD_W-1:0] out_row;
    logic [OUT_COORD_W-1:0] out_col;
    logic [OUT_CHAN_W-1:0]  channel;
    logic [OUT_ARG_W-1:0]   arg_row;
    logic [OUT_ARG_W-1:0]   arg_col;
    logic                   last_of_frame;
    logic                   bad_config;

    int error_count;
    int pending;
    int tx_gap_max = GAP_MAX;
    int rx_gap_max = GAP_MAX;
    bit rx_hold = 1'b0;

    max_pool_2d_with_argmax_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .max_value     (max_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .channel       (channel),
        .arg_row       (arg_row),
        .arg_col       (arg_col),
        .last_of_frame (last_of_frame),
        .bad_config    (bad_config)
    );

    max_pool_argmax_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .max_value     (max_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .channel       (channel),
        .arg_row       (arg_row),
        .arg_col       (arg_col),
        .last_of_frame (last_of_frame),
        .bad_config    (bad_config),
        .error_count   (error_count),
        .pending       (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // extremes, small values for ties, and full-range noise
    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] v;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = MOST_NEG;
                    1:       v = MOST_POS;
                    2:       v = 16'sh0000;
                    default: v = -16'sd1;
                endcase
            end
            1:       v = $urandom_range(0, 6) - 3;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic push_sample(input logic signed [15:0] value, input logic start);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= value;
        frame_start <= start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // registers change only once the block has gone quiet
    task automatic configure(input int pool, input int width, input int chans, input bit spare);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_POOL_WIDTH, pool);
        write_reg(CFG_IN_WIDTH, width);
        write_reg(CFG_CHANNELS, chans);
        if (spare)
            write_reg(CFG_SPARE, $urandom);
        cfg_we <= 1'b0;
    endtask

    task automatic run_map(input int pool, input int width, input int chans, input int count);
        configure(pool, width, chans, $urandom_range(0, 5) == 0);
        for (int n = 0; n < count; n++)
            push_sample(pick_sample(), n == 0 || $urandom_range(0, 39) == 0);
    endtask

    // result side
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_hold)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold = 1'b0;
            end
            gap = $urandom_range(0, rx_gap_max);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        #5000000;
        $display("tb_max_pool_2d_with_argmax_unit: done, errors");
        $finish;
    end

    initial
    begin
        int fed;
        int pool;
        int width;
        int chans;
        int count;
        int drain_wait;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        sample      = '0;
        frame_start = 1'b0;
        fed         = 0;
        drain_wait  = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ties keep the first maximum, then a second map follows with no start mark
        configure(2, 2, 1, 1'b1);
        push_sample(MOST_NEG, 1'b1);
        push_sample(MOST_POS, 1'b0);
        push_sample(MOST_POS, 1'b0);
        push_sample(16'sh0000, 1'b0);
        repeat (4) push_sample(MOST_NEG, 1'b0);

        // one-sample map, every sample closes the map
        configure(1, 1, 1, 1'b0);
        push_sample(16'sh0100, 1'b1);
        push_sample(-16'sd1, 1'b0);

        // fewer channels leaves the position outside the map, next sample restarts it
        configure(2, 2, 4, 1'b0);
        push_sample(pick_sample(), 1'b1);
        repeat (2) push_sample(pick_sample(), 1'b0);
        configure(2, 2, 2, 1'b0);
        repeat (8) push_sample(pick_sample(), 1'b0);

        // map width not a multiple of the window
        configure(3, 4, 1, 1'b0);
        push_sample(pick_sample(), 1'b1);
        push_sample(pick_sample(), 1'b0);

        run_map(8, 8, 1, 64);
        run_map(2, 2, 16, 64);

        // widest map with a long output stall while samples keep coming back to back
        tx_gap_max = 0;
        rx_hold    = 1'b1;
        run_map(1, 64, 1, 130);

        while (fed < RANDOM_ITEMS)
        begin
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            if ($urandom_range(0, 7) == 0)
            begin
                pool  = 2;
                width = 8;
                chans = 1;
                case ($urandom_range(0, 3))
                    0: pool = $urandom_range(0, 1) ? 0 : $urandom_range(POOL_LIMIT + 1, 15);
                    1: width = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
                    2: chans = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
                    default:
                    begin
                        pool  = $urandom_range(2, POOL_LIMIT);
                        width = pool * $urandom_range(1, 4) + $urandom_range(1, pool - 1);
                    end
                endcase
                count = $urandom_range(3, 8);
            end
            else
            begin
                pool = $urandom_range(1, POOL_LIMIT);
                if ($urandom_range(0, 9) == 0)
                    width = pool * (64 / pool);
                else
                    width = pool * $urandom_range(1, 16 / pool);
                chans = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 4);
                count = width * width * chans * $urandom_range(1, 2);
                if (count > PHASE_CAP)
                    count = PHASE_CAP;
            end
            run_map(pool, width, chans, count);
            fed += count;
        end

        in_valid <= 1'b0;
        while (pending != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain_wait++;
        end
        if (pending != 0)
            $display("tb_max_pool_2d_with_argmax_unit: done, errors");
        else
        begin
            repeat (SETTLE_CYCLES) @(negedge clk);
            if (error_count == 0)
                $display("tb_max_pool_2d_with_argmax_unit: done, clean");
            else
                $display("tb_max_pool_2d_with_argmax_unit: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
